FILE: design/goc_pkg.sv
// Shared types and constants for the gyro offset calibration / moving average block.
// No dependencies; imported by every module of the block except goc_cdiv.
package goc_pkg;

  localparam int SAMPLE_W = 16;

  // Latency of the constant divider in cycles.
  localparam int DIV_LAT  = 4;
  // Pipeline positions, counted in registers after the accept edge.
  localparam int CORR_STG = 1 + DIV_LAT;    // bias ready, sample is corrected
  localparam int SUM_STG  = CORR_STG + 1;   // ring write and window sum update
  localparam int OUT_STG  = SUM_STG + 1 + DIV_LAT;

  typedef struct packed {
    logic adv;        // pipeline moves this cycle
    logic cap_acc;    // accepted item belongs to a capture
    logic cap_done;   // accepted item completes the capture
    logic bias_upd;   // item at the correction stage loads the new bias
    logic rd_zero;    // ring slot being read was never written
    logic wr_en;      // item at the sum stage writes the ring
  } goc_ctl_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] rate_x;
    logic signed [SAMPLE_W-1:0] rate_y;
    logic signed [SAMPLE_W-1:0] rate_z;
    logic                       calibrating;
    logic                       calibration_done;
  } goc_res_t;

endpackage

FILE: design/goc_cdiv.sv
// Pipelined signed division by a constant, truncated toward zero.
// Reciprocal multiply with one correction step; standalone, no package use.
module goc_cdiv #(
  parameter int DIVISOR = 8,
  parameter int IN_W    = 19,
  parameter int OUT_W   = 16
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [IN_W-1:0]  din,
  output logic signed [OUT_W-1:0] dout
);

  localparam int MW = IN_W;
  localparam longint unsigned RECIP_L = (64'd1 << MW) / DIVISOR;
  localparam logic [MW-1:0] RECIP = MW'(RECIP_L);
  localparam logic [MW-1:0] DIV_C = MW'(DIVISOR);

  logic [MW-1:0]   din_u;
  logic [MW-1:0]   mag_a;
  logic            neg_a;
  logic [2*MW-1:0] prod_b;
  logic [MW-1:0]   mag_b;
  logic            neg_b;
  logic [MW-1:0]   q_c;
  logic            ge_c;
  logic            neg_c;
  logic [MW-1:0]   q_est;
  logic [MW-1:0]   qd;
  logic [MW-1:0]   rem;
  logic [MW-1:0]   q_fin;
  logic [MW-1:0]   q_sgn;

  assign din_u = din;

  always_comb begin
    q_est = prod_b[2*MW-1:MW];
    qd    = q_est * DIV_C;
    rem   = mag_b - qd;
    q_fin = q_c + MW'(ge_c);
    q_sgn = neg_c ? (~q_fin + MW'(1)) : q_fin;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // magnitude and sign
      neg_a  <= din[IN_W-1];
      mag_a  <= din[IN_W-1] ? (~din_u + MW'(1)) : din_u;
      // reciprocal product, quotient estimate is low by at most one
      prod_b <= (2*MW)'(mag_a) * (2*MW)'(RECIP);
      mag_b  <= mag_a;
      neg_b  <= neg_a;
      // remainder check
      q_c    <= q_est;
      ge_c   <= (rem >= DIV_C);
      neg_c  <= neg_b;
      // fix up and restore sign
      dout   <= signed'(q_sgn[OUT_W-1:0]);
    end
  end

endmodule

FILE: design/goc_lane.sv
// One axis lane: capture sum, bias divider, correction, sample ring and window average.
// Depends on goc_pkg and goc_cdiv.
module goc_lane #(
  parameter int WINDOW      = 8,
  parameter int CAL_SAMPLES = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  goc_pkg::goc_ctl_t                    ctl,
  input  logic [$clog2(WINDOW)-1:0]            rd_ptr,
  input  logic [$clog2(WINDOW)-1:0]            wr_ptr,
  input  logic signed [goc_pkg::SAMPLE_W-1:0]  gyro,
  output logic signed [goc_pkg::SAMPLE_W-1:0]  rate
);

  import goc_pkg::*;

  localparam int CS_W = SAMPLE_W + $clog2(CAL_SAMPLES);
  localparam int WS_W = SAMPLE_W + $clog2(WINDOW);
  localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  logic signed [CS_W-1:0]     csum;
  logic signed [CS_W-1:0]     csum_next;
  logic signed [CS_W-1:0]     csum_p1;
  logic signed [SAMPLE_W-1:0] bias_q;
  logic signed [SAMPLE_W-1:0] bias;
  logic signed [SAMPLE_W-1:0] bias_eff;
  logic signed [SAMPLE_W-1:0] samp [1:CORR_STG];
  logic signed [SAMPLE_W:0]   diff;
  logic signed [SAMPLE_W-1:0] corr;
  logic signed [SAMPLE_W-1:0] c6;
  logic signed [SAMPLE_W-1:0] ring [WINDOW];
  logic signed [SAMPLE_W-1:0] ring_q;
  logic                       zero6;
  logic signed [SAMPLE_W-1:0] old6;
  logic signed [WS_W-1:0]     wsum;

  assign csum_next = csum + CS_W'(gyro);
  assign bias_eff  = ctl.bias_upd ? bias_q : bias;
  assign diff      = (SAMPLE_W+1)'(samp[CORR_STG]) - (SAMPLE_W+1)'(bias_eff);
  assign old6      = zero6 ? '0 : ring_q;

  always_comb begin
    if (diff[SAMPLE_W] != diff[SAMPLE_W-1]) begin
      corr = diff[SAMPLE_W] ? S_MIN : S_MAX;
    end else begin
      corr = diff[SAMPLE_W-1:0];
    end
  end

  // control-side state
  always_ff @(posedge clk) begin
    if (rst) begin
      csum <= '0;
      bias <= '0;
      wsum <= '0;
    end else begin
      if (ctl.cap_acc) begin
        csum <= ctl.cap_done ? '0 : csum_next;
      end
      if (ctl.adv && ctl.bias_upd) begin
        bias <= bias_q;
      end
      if (ctl.adv && ctl.wr_en) begin
        wsum <= wsum - WS_W'(old6) + WS_W'(c6);
      end
    end
  end

  // payload path and ring memory
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      csum_p1 <= csum_next;
      samp[1] <= gyro;
      for (int i = 2; i <= CORR_STG; i++) begin
        samp[i] <= samp[i-1];
      end
      c6     <= corr;
      ring_q <= ring[rd_ptr];
      zero6  <= ctl.rd_zero;
      if (ctl.wr_en) begin
        ring[wr_ptr] <= c6;
      end
    end
  end

  goc_cdiv #(
    .DIVISOR (CAL_SAMPLES),
    .IN_W    (CS_W),
    .OUT_W   (SAMPLE_W)
  ) u_bias_div (
    .clk  (clk),
    .en   (ctl.adv),
    .din  (csum_p1),
    .dout (bias_q)
  );

  goc_cdiv #(
    .DIVISOR (WINDOW),
    .IN_W    (WS_W),
    .OUT_W   (SAMPLE_W)
  ) u_rate_div (
    .clk  (clk),
    .en   (ctl.adv),
    .din  (wsum),
    .dout (rate)
  );

endmodule

FILE: design/goc_ctrl.sv
// Shared control: capture sequencing, pipeline valid and flag delay lines, ring pointers.
// Depends on goc_pkg.
module goc_ctrl #(
  parameter int WINDOW      = 8,
  parameter int CAL_SAMPLES = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      acc,
  input  logic                      request_calibration,
  output goc_pkg::goc_ctl_t         ctl,
  output logic [$clog2(WINDOW)-1:0] rd_ptr,
  output logic [$clog2(WINDOW)-1:0] wr_ptr,
  output logic                      item_valid,
  output logic                      item_calibrating,
  output logic                      item_done
);

  import goc_pkg::*;

  localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
  localparam int PTR_W = $clog2(WINDOW);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);

  logic             active;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             active_eff;
  logic             done0;
  logic             ring_full;
  logic             v_pipe    [1:OUT_STG];
  logic             done_pipe [1:OUT_STG];
  logic             cal_pipe  [1:OUT_STG];

  assign active_eff = active | request_calibration;
  assign count_next = count + CNT_W'(1);
  assign done0      = active_eff && (count_next == CNT_W'(CAL_SAMPLES));

  assign ctl = '{
    adv:      adv,
    cap_acc:  acc & active_eff,
    cap_done: done0,
    bias_upd: v_pipe[CORR_STG] & done_pipe[CORR_STG],
    rd_zero:  ~ring_full,
    wr_en:    v_pipe[SUM_STG]
  };

  assign item_valid       = v_pipe[OUT_STG];
  assign item_calibrating = cal_pipe[OUT_STG];
  assign item_done        = done_pipe[OUT_STG];

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      count     <= '0;
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      ring_full <= 1'b0;
      for (int i = 1; i <= OUT_STG; i++) begin
        v_pipe[i]    <= 1'b0;
        done_pipe[i] <= 1'b0;
        cal_pipe[i]  <= 1'b0;
      end
    end else begin
      if (acc && active_eff) begin
        active <= ~done0;
        count  <= done0 ? '0 : count_next;
      end
      if (adv) begin
        v_pipe[1]    <= acc;
        done_pipe[1] <= acc & done0;
        cal_pipe[1]  <= active_eff & ~done0;
        for (int i = 2; i <= OUT_STG; i++) begin
          v_pipe[i]    <= v_pipe[i-1];
          done_pipe[i] <= done_pipe[i-1];
          cal_pipe[i]  <= cal_pipe[i-1];
        end
        if (v_pipe[CORR_STG]) begin
          rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
          if (rd_ptr == PTR_LAST) begin
            ring_full <= 1'b1;
          end
        end
        if (v_pipe[SUM_STG]) begin
          wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
        end
      end
    end
  end

endmodule

FILE: design/gyro_offset_cal_moving_average.sv
// An accepted item passes the capture sum register, bias divider, correction and window sum
// registers, rate divider and output register. Throughput: one item per cycle while sample_stall
// is low; the dividers, bias update and ring read/write share one pipeline that advances as a whole.
// Reset (rst, synchronous): bias, capture sums and count, window sums and ring pointers
// clear; ring slots never written since reset read as zero via a wrap flag, no clearing pass.
// A one-entry skid behind the output register keeps sample_stall a registered signal.
module gyro_offset_cal_moving_average #(
  parameter int WINDOW      = 8,
  parameter int CAL_SAMPLES = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic signed [goc_pkg::SAMPLE_W-1:0] gyro_x,
  input  logic signed [goc_pkg::SAMPLE_W-1:0] gyro_y,
  input  logic signed [goc_pkg::SAMPLE_W-1:0] gyro_z,
  input  logic                                request_calibration,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic signed [goc_pkg::SAMPLE_W-1:0] rate_x,
  output logic signed [goc_pkg::SAMPLE_W-1:0] rate_y,
  output logic signed [goc_pkg::SAMPLE_W-1:0] rate_z,
  output logic                                calibrating,
  output logic                                calibration_done
);

  import goc_pkg::*;

  localparam int PTR_W = $clog2(WINDOW);

  goc_ctl_t   ctl;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic       adv;
  logic       acc;
  logic       pipe_v;
  logic       pipe_cal;
  logic       pipe_done;
  logic signed [SAMPLE_W-1:0] lane_rate_x;
  logic signed [SAMPLE_W-1:0] lane_rate_y;
  logic signed [SAMPLE_W-1:0] lane_rate_z;
  goc_res_t   pipe_res;
  goc_res_t   out_q;
  goc_res_t   sk_q;
  logic       sk_v;
  logic       out_take;

  // The whole pipeline holds only while the skid entry is occupied.
  assign adv          = ~sk_v;
  assign sample_stall = sk_v;
  assign acc          = sample_valid & ~sample_stall;
  assign out_take     = result_valid & ~result_stall;

  goc_ctrl #(
    .WINDOW      (WINDOW),
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_ctrl (
    .clk                 (clk),
    .rst                 (rst),
    .adv                 (adv),
    .acc                 (acc),
    .request_calibration (request_calibration),
    .ctl                 (ctl),
    .rd_ptr              (rd_ptr),
    .wr_ptr              (wr_ptr),
    .item_valid          (pipe_v),
    .item_calibrating    (pipe_cal),
    .item_done           (pipe_done)
  );

  // One lane per axis, all driven by the same control word.
  goc_lane #(
    .WINDOW      (WINDOW),
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_lane_x (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .rd_ptr (rd_ptr),
    .wr_ptr (wr_ptr),
    .gyro   (gyro_x),
    .rate   (lane_rate_x)
  );

  goc_lane #(
    .WINDOW      (WINDOW),
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_lane_y (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .rd_ptr (rd_ptr),
    .wr_ptr (wr_ptr),
    .gyro   (gyro_y),
    .rate   (lane_rate_y)
  );

  goc_lane #(
    .WINDOW      (WINDOW),
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_lane_z (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .rd_ptr (rd_ptr),
    .wr_ptr (wr_ptr),
    .gyro   (gyro_z),
    .rate   (lane_rate_z)
  );

  assign pipe_res = '{
    rate_x:           lane_rate_x,
    rate_y:           lane_rate_y,
    rate_z:           lane_rate_z,
    calibrating:      pipe_cal,
    calibration_done: pipe_done
  };

  // Merge the lanes into one result item; output register plus one skid entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      sk_v         <= 1'b0;
    end else begin
      if (sk_v) begin
        // pipeline is held; drain the skid entry first
        if (out_take) begin
          out_q <= sk_q;
          sk_v  <= 1'b0;
        end
      end else if (pipe_v) begin
        if (!result_valid || !result_stall) begin
          out_q        <= pipe_res;
          result_valid <= 1'b1;
        end else begin
          // output is stalled: park the arriving item
          sk_q <= pipe_res;
          sk_v <= 1'b1;
        end
      end else if (out_take) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign rate_x           = out_q.rate_x;
  assign rate_y           = out_q.rate_y;
  assign rate_z           = out_q.rate_z;
  assign calibrating      = out_q.calibrating;
  assign calibration_done = out_q.calibration_done;

  // The skid entry is only ever filled behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    sk_v |-> result_valid)
    else $error("skid entry occupied with no result waiting");

  // A stalled result with an arriving item must park that item.
  a_skid_fills: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall && !sk_v && pipe_v) |=> sk_v)
    else $error("arriving item not parked while output stalled");

  // The completing item of a capture already reports the capture as ended.
  a_done_ends_cal: assert property (@(posedge clk) disable iff (rst)
    (result_valid && calibration_done) |-> !calibrating)
    else $error("calibration_done together with calibrating");

  // While the skid entry is held, no new item enters the pipeline.
  a_no_accept_full: assert property (@(posedge clk) disable iff (rst)
    sk_v |-> !acc)
    else $error("item accepted while pipeline is held");

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for gyro_offset_cal_moving_average: bias capture and the
// bias-removed moving average, predicted per item and compared per result.
// Depends on goc_pkg and the gyro_offset_cal_moving_average RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import goc_pkg::*;

  // Keep these equal to the parameters handed to the DUT below.
  localparam int WINDOW       = 8;
  localparam int CAL_SAMPLES  = 256;
  // Cycles with no item moving on either side before the run is declared hung.
  localparam int STALL_LIMIT  = 2000;
  // Settle time after the last result; comfortably above the pipeline latency.
  localparam int DRAIN_CYCLES = 24;
  localparam longint SAT_MAX  = 32767;
  localparam longint SAT_MIN  = -32768;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
    logic signed [SAMPLE_W-1:0] z;
    logic                       req;
  } gyro_item_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       sample_valid = 1'b0;
  logic                       sample_stall;
  logic signed [SAMPLE_W-1:0] gyro_x = '0;
  logic signed [SAMPLE_W-1:0] gyro_y = '0;
  logic signed [SAMPLE_W-1:0] gyro_z = '0;
  logic                       request_calibration = 1'b0;
  logic                       result_valid;
  logic                       result_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] rate_x;
  logic signed [SAMPLE_W-1:0] rate_y;
  logic signed [SAMPLE_W-1:0] rate_z;
  logic                       calibrating;
  logic                       calibration_done;

  // Predictor state: bias, capture accumulators and the per-axis ring.
  longint bias [3];
  longint cal_sum [3];
  int     cal_count;
  bit     cal_active;
  longint ring [WINDOW][3];
  longint win_sum [3];
  int     ring_ptr;

  // Expected results, oldest first.
  goc_res_t pending_rates [$];
  int       error_count = 0;
  // Idling on/off for both sides; flipped now and then to get quiet stretches.
  bit       idle_on = 1'b1;
  int       stall_left = 0;
  int       quiet_cycles = 0;

  gyro_offset_cal_moving_average #(
    .WINDOW     (WINDOW),
    .CAL_SAMPLES(CAL_SAMPLES)
  ) DUT (
    .clk                (clk),
    .rst                (rst),
    .sample_valid       (sample_valid),
    .sample_stall       (sample_stall),
    .gyro_x             (gyro_x),
    .gyro_y             (gyro_y),
    .gyro_z             (gyro_z),
    .request_calibration(request_calibration),
    .result_valid       (result_valid),
    .result_stall       (result_stall),
    .rate_x             (rate_x),
    .rate_y             (rate_y),
    .rate_z             (rate_z),
    .calibrating        (calibrating),
    .calibration_done   (calibration_done)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_filter();
    for (int a = 0; a < 3; a++) begin
      bias[a]    = 0;
      cal_sum[a] = 0;
      win_sum[a] = 0;
      for (int w = 0; w < WINDOW; w++) ring[w][a] = 0;
    end
    cal_count  = 0;
    cal_active = 1'b0;
    ring_ptr   = 0;
  endfunction

  // Advance the filter by one sample and return the rates it should produce.
  function automatic goc_res_t predict_rates(gyro_item_t it);
    longint   s [3];
    longint   avg [3];
    longint   c;
    goc_res_t r;
    s[0] = it.x;
    s[1] = it.y;
    s[2] = it.z;
    r.calibration_done = 1'b0;

    // A request only starts a capture on an idle block; the current sample counts.
    if (!cal_active && it.req) begin
      cal_active = 1'b1;
      cal_count  = 0;
      for (int a = 0; a < 3; a++) cal_sum[a] = 0;
    end

    // Capture first, so the completing sample is corrected with the new bias.
    if (cal_active) begin
      for (int a = 0; a < 3; a++) cal_sum[a] += s[a];
      cal_count++;
      if (cal_count >= CAL_SAMPLES) begin
        for (int a = 0; a < 3; a++) begin
          bias[a]    = cal_sum[a] / CAL_SAMPLES;   // truncates toward zero
          cal_sum[a] = 0;
        end
        cal_count          = 0;
        cal_active         = 1'b0;
        r.calibration_done = 1'b1;
      end
    end

    // Subtract bias, saturate, swap into the ring slot and update the running sum.
    for (int a = 0; a < 3; a++) begin
      c = s[a] - bias[a];
      if (c > SAT_MAX) c = SAT_MAX;
      else if (c < SAT_MIN) c = SAT_MIN;
      win_sum[a] -= ring[ring_ptr][a];
      ring[ring_ptr][a] = c;
      win_sum[a] += c;
      avg[a] = win_sum[a] / WINDOW;
    end
    ring_ptr = (ring_ptr + 1) % WINDOW;

    r.rate_x      = avg[0][SAMPLE_W-1:0];
    r.rate_y      = avg[1][SAMPLE_W-1:0];
    r.rate_z      = avg[2][SAMPLE_W-1:0];
    r.calibrating = cal_active;
    return r;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor and scoreboard: predict on every accepted sample, check every
  // accepted result against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    gyro_item_t seen;
    goc_res_t   want;
    if (!rst) begin
      if (sample_valid && !sample_stall) begin
        seen = '{x: gyro_x, y: gyro_y, z: gyro_z, req: request_calibration};
        pending_rates.push_back(predict_rates(seen));
      end
      if (result_valid && !result_stall) begin
        if (pending_rates.size() == 0) begin
          $error("result with no sample pending: rate_x %0d rate_y %0d rate_z %0d",
                 rate_x, rate_y, rate_z);
          error_count++;
        end else begin
          want = pending_rates.pop_front();
          check_field("rate_x", want.rate_x, rate_x);
          check_field("rate_y", want.rate_y, rate_y);
          check_field("rate_z", want.rate_z, rate_z);
          check_field("calibrating", want.calibrating, calibrating);
          check_field("calibration_done", want.calibration_done, calibration_done);
        end
      end
    end
  end

  // Receiver: stall in random bursts, mostly short, now and then long.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      result_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 99) < 30) begin
      result_stall <= 1'b1;
      stall_left   <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 2);
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long.
  always @(posedge clk) begin
    if ((sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL gyro_offset_cal_moving_average");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender helpers
  // ---------------------------------------------------------------------------

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] clip16(int v);
    if (v > SAT_MAX) return SAT_MAX[SAMPLE_W-1:0];
    if (v < SAT_MIN) return SAT_MIN[SAMPLE_W-1:0];
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic gyro_item_t make_item(int x, int y, int z, bit req);
    return '{x: clip16(x), y: clip16(y), z: clip16(z), req: req};
  endfunction

  // Random value: full 16-bit range when spread covers it, else center +/- spread.
  function automatic logic signed [SAMPLE_W-1:0] jitter(int center, int spread);
    logic [31:0] raw;
    if (spread >= 32768) begin
      raw = $urandom;
      return raw[SAMPLE_W-1:0];
    end
    return clip16(center + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  // Drive one item after a random gap and hold it until accepted. Valid stays
  // high afterwards so back-to-back items need no re-raise.
  task automatic send_sample(input gyro_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid        <= 1'b1;
    gyro_x              <= it.x;
    gyro_y              <= it.y;
    gyro_z              <= it.z;
    request_calibration <= it.req;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    if ($urandom_range(0, 63) == 0) idle_on = !idle_on;
  endtask

  // Drop valid and hold until every predicted result has been checked.
  task automatic wait_for_results();
    sample_valid <= 1'b0;
    while (pending_rates.size() != 0) @(posedge clk);
  endtask

  // One full capture: request on the first sample, CAL_SAMPLES samples around a
  // center. Extra requests sprinkled inside must be ignored by the block.
  task automatic run_capture(input int cx, input int cy, input int cz,
                             input int spread, input int req_pct);
    gyro_item_t it;
    for (int i = 0; i < CAL_SAMPLES; i++) begin
      it.x   = jitter(cx, spread);
      it.y   = jitter(cy, spread);
      it.z   = jitter(cz, spread);
      it.req = (i == 0) || ($urandom_range(0, 99) < req_pct);
      send_sample(it);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Ring warm-up from the cleared state, field extremes, rounding of small sums.
  task automatic test_warmup_extremes();
    send_sample(make_item(0, 0, 0, 1'b0));
    send_sample(make_item(32767, -32768, 0, 1'b0));
    send_sample(make_item(-32768, 32767, -1, 1'b0));
    send_sample(make_item(-1, 7, -7, 1'b0));
    // Fill the whole window with extremes: largest positive and negative sums.
    for (int i = 0; i < WINDOW; i++)
      send_sample(make_item(32767, -32768, (i % 2) ? 32767 : -32768, 1'b0));
    for (int i = 0; i < WINDOW; i++)
      send_sample(make_item(-32768, 32767, -3, 1'b0));
    // Small negative sums must truncate toward zero.
    for (int i = 0; i < 3; i++)
      send_sample(make_item(-1, 1, -9, 1'b0));
  endtask

  // Capture over full-range samples with repeated requests that must not restart it.
  task automatic test_capture_ignores_request();
    run_capture(0, 0, 0, 32768, 25);
  endtask

  // Large biases, then samples on the far side so the correction saturates. The
  // first capture starts on the item right after the previous one finished.
  task automatic test_correction_saturation();
    run_capture(30000, -30000, 25000, 2000, 10);
    for (int i = 0; i < 10; i++)
      send_sample(make_item(-32768, 32767, (i < 5) ? -32768 : 32767, 1'b0));
    run_capture(-30000, 30000, -25000, 2000, 10);
    for (int i = 0; i < 10; i++)
      send_sample(make_item(32767, -32768, (i < 5) ? 32767 : -32768, 1'b0));
  endtask

  // Let the pipeline run dry, then restart with a burst free of idling.
  task automatic test_drain_and_restart();
    bit saved_idle;
    wait_for_results();
    saved_idle = idle_on;
    idle_on    = 1'b0;
    for (int i = 0; i < 20; i++)
      send_sample(make_item(jitter(0, 32768), jitter(0, 32768), jitter(0, 32768),
                            1'b0));
    idle_on = saved_idle;
  endtask

  // Full-range noise with the odd request; any capture it starts runs on.
  task automatic test_random_noise();
    gyro_item_t it;
    for (int i = 0; i < 300; i++) begin
      it.x   = jitter(0, 32768);
      it.y   = jitter(0, 32768);
      it.z   = jitter(0, 32768);
      it.req = ($urandom_range(0, 99) < 3);
      send_sample(it);
    end
  endtask

  initial begin
    clear_filter();
    // Hold reset from the start, then release it.
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_warmup_extremes();
    test_capture_ignores_request();
    test_correction_saturation();
    test_drain_and_restart();
    test_random_noise();

    // Wait for every result, then a few more cycles to catch strays.
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS gyro_offset_cal_moving_average");
    end else begin
      $display("FAIL gyro_offset_cal_moving_average");
    end
    $finish;
  end

endmodule
